@@ hw/rtl/bzp_pkg.sv @@
package bzp_pkg;

	localparam int COORD_BITS = 16;
	localparam int COEF_W = 21;
	localparam int MIN_W = 7;
	localparam int IDX_W = 6;
	localparam int DEF_MAX_POINTS = 64;

	// Endpoint deltas, their squares and the integer root of distance / 10.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int D2_W = 2 * DIFF_W;
	localparam int ROOT_W = COORD_BITS - 2;

	// Q1.16 curve parameter and the Horner sums.
	localparam int FRAC_BITS = 16;
	localparam int DIV_W = FRAC_BITS + 1;
	localparam int T_W = DIV_W + 1;
	localparam int S1_W = COEF_W + T_W + 1;
	localparam int S2_W = S1_W + 4;
	localparam int S3_W = S2_W + 4;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] p0_x;
		logic signed [COORD_BITS-1:0] p0_y;
		logic signed [COORD_BITS-1:0] p1_x;
		logic signed [COORD_BITS-1:0] p1_y;
		logic signed [COORD_BITS-1:0] p2_x;
		logic signed [COORD_BITS-1:0] p2_y;
		logic signed [COORD_BITS-1:0] p3_x;
		logic signed [COORD_BITS-1:0] p3_y;
		logic [MIN_W-1:0] min_points;
	} curve_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic [IDX_W-1:0] point_index;
		logic last_point;
	} point_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a_x;
		logic signed [COEF_W-1:0] a_y;
		logic signed [COEF_W-1:0] b_x;
		logic signed [COEF_W-1:0] b_y;
		logic signed [COEF_W-1:0] c_x;
		logic signed [COEF_W-1:0] c_y;
		logic signed [COORD_BITS-1:0] p0_x;
		logic signed [COORD_BITS-1:0] p0_y;
	} coef_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SQ,
		F_SUM,
		F_ROOT,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} back_state_t;

endpackage

@@ hw/rtl/bzp_front.sv @@
module bzp_front #(
	parameter int MAX_POINTS = bzp_pkg::DEF_MAX_POINTS
) (
	input  logic clk,
	input  logic arst_n,
	input  bzp_pkg::curve_t curve,
	input  logic push,
	output logic full,
	output bzp_pkg::coef_t coef,
	output logic [$clog2(MAX_POINTS+1)-1:0] count,
	output logic q_push,
	input  logic q_full
);
	import bzp_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int BIT_W = $clog2(ROOT_W);
	localparam int PROD_W = 2 * ROOT_W + 7;

	front_state_t state_q, state_d;
	coef_t coef_q, coef_d;
	logic [MIN_W-1:0] min_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [D2_W-1:0] sqx_q, sqy_q;
	logic [D2_W:0] d2_q;
	logic [ROOT_W-1:0] root_q, trial;
	logic [BIT_W-1:0] bit_q;
	logic [2*ROOT_W-1:0] trial_sq;
	logic [PROD_W-1:0] trial_prod;
	logic [31:0] cnt_w;
	logic signed [COEF_W-1:0] d1x, d1y, d2x, d2y;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (push) state_d = F_SQ;
			F_SQ: state_d = F_SUM;
			F_SUM: state_d = F_ROOT;
			F_ROOT: if (bit_q == '0) state_d = F_PUSH;
			F_PUSH: if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full = (state_q != F_IDLE);
		q_push = (state_q == F_PUSH) && !q_full;
	end

	// Power-basis coefficients: c = 3(p1-p0), b = 3(p2-p1) - c, a = p3 - p0 - c - b.
	always_comb begin
		d1x = COEF_W'(curve.p1_x) - COEF_W'(curve.p0_x);
		d1y = COEF_W'(curve.p1_y) - COEF_W'(curve.p0_y);
		d2x = COEF_W'(curve.p2_x) - COEF_W'(curve.p1_x);
		d2y = COEF_W'(curve.p2_y) - COEF_W'(curve.p1_y);
		coef_d.c_x = (d1x <<< 1) + d1x;
		coef_d.c_y = (d1y <<< 1) + d1y;
		coef_d.b_x = (d2x <<< 1) + d2x - coef_d.c_x;
		coef_d.b_y = (d2y <<< 1) + d2y - coef_d.c_y;
		coef_d.a_x = COEF_W'(curve.p3_x) - COEF_W'(curve.p0_x) - coef_d.c_x - coef_d.b_x;
		coef_d.a_y = COEF_W'(curve.p3_y) - COEF_W'(curve.p0_y) - coef_d.c_y - coef_d.b_y;
		coef_d.p0_x = curve.p0_x;
		coef_d.p0_y = curve.p0_y;
	end

	// One root bit per cycle: keep the bit if 100 * trial^2 still fits under d2.
	always_comb begin
		trial = root_q | (ROOT_W'(1) << bit_q);
		trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);
		trial_prod = PROD_W'(trial_sq) * PROD_W'(100);
	end

	always_comb begin
		cnt_w = 32'(root_q);
		if (32'(min_q) > cnt_w) cnt_w = 32'(min_q);
		if (cnt_w < 32'd2) cnt_w = 32'd2;
		if (cnt_w > 32'(MAX_POINTS)) cnt_w = 32'(MAX_POINTS);
		count = CNT_W'(cnt_w);
		coef = coef_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (push) begin
					coef_q <= coef_d;
					min_q <= curve.min_points;
					dx_q <= DIFF_W'(curve.p3_x) - DIFF_W'(curve.p0_x);
					dy_q <= DIFF_W'(curve.p3_y) - DIFF_W'(curve.p0_y);
				end
			end
			F_SQ: begin
				sqx_q <= D2_W'(dx_q) * D2_W'(dx_q);
				sqy_q <= D2_W'(dy_q) * D2_W'(dy_q);
			end
			F_SUM: begin
				d2_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
				root_q <= '0;
				bit_q <= BIT_W'(ROOT_W - 1);
			end
			F_ROOT: begin
				if (trial_prod <= d2_q) root_q <= trial;
				bit_q <= bit_q - BIT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/bzp_queue.sv @@
module bzp_queue #(
	parameter int DATA_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	output logic full,
	input  logic [DATA_W-1:0] din,
	input  logic rd,
	output logic empty,
	output logic [DATA_W-1:0] dout
);

	logic [DATA_W-1:0] slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	always_comb begin
		full = (fill_q == 2'd2);
		empty = (fill_q == 2'd0);
		dout = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (wr) wr_ptr_q <= ~wr_ptr_q;
			if (rd) rd_ptr_q <= ~rd_ptr_q;
			if (wr && !rd) fill_q <= fill_q + 2'd1;
			else if (rd && !wr) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wr_ptr_q] <= din;
	end

endmodule

@@ hw/rtl/bzp_back.sv @@
module bzp_back #(
	parameter int MAX_POINTS = bzp_pkg::DEF_MAX_POINTS
) (
	input  logic clk,
	input  logic arst_n,
	input  bzp_pkg::coef_t coef,
	input  logic [$clog2(MAX_POINTS+1)-1:0] count,
	input  logic q_empty,
	output logic q_pop,
	output bzp_pkg::point_t point,
	output logic empty,
	input  logic pop
);
	import bzp_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int STEP_W = $clog2(DIV_W);
	localparam int M2_W = S1_W + T_W;
	localparam int M3_W = S2_W + T_W;
	localparam logic signed [S3_W-1:0] CMAX = (S3_W'(1) <<< (COORD_BITS - 1)) - S3_W'(1);
	localparam logic signed [S3_W-1:0] CMIN = -CMAX - S3_W'(1);
	localparam logic signed [S3_W-1:0] HALF = S3_W'(1) <<< (FRAC_BITS - 1);

	back_state_t state_q, state_d;
	coef_t coef_q;
	logic [CNT_W-1:0] n_q, rem_q, frac_q, idx_q;
	logic [DIV_W-1:0] num_q, quo_q, t_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0] sh, frac_sum;
	logic en, issue, busy;

	logic v_s1, v_s2, v_s3, last_s1, last_s2, last_s3;
	logic [CNT_W-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [T_W-1:0] t_e, t_s1, t_s2;
	logic signed [COEF_W-1:0] a_ax [2], b_ax [2], c_ax [2];
	logic signed [COORD_BITS-1:0] p0_ax [2];
	logic signed [S1_W-1:0] s1_d [2], s1_s1 [2];
	logic signed [S2_W-1:0] s2_d [2], s2_s2 [2];
	logic signed [S3_W-1:0] s3_d [2], s3_s3 [2];
	logic signed [M2_W-1:0] m2 [2];
	logic signed [M3_W-1:0] m3 [2];
	logic signed [S3_W-1:0] rnd [2];
	logic signed [COORD_BITS-1:0] sat [2];
	logic out_v_q;
	point_t point_q;

	// The whole point pipeline moves only when the output register is free or drained.
	assign en = !out_v_q || pop;
	assign busy = v_s1 || v_s2 || v_s3;
	assign issue = (state_q == B_EMIT) && en;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (!q_empty && !busy) state_d = B_DIV;
			B_DIV: if (step_q == '0) state_d = B_EMIT;
			B_EMIT: if (issue && idx_q == n_q) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == B_IDLE) && !q_empty && !busy;
		empty = !out_v_q;
		point = point_q;
	end

	// Restoring division of 2^16 by count-1 gives the t step as quotient plus remainder.
	always_comb begin
		sh = {rem_q, num_q[DIV_W-1]};
		frac_sum = {1'b0, frac_q} + {1'b0, rem_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_pop) begin
					coef_q <= coef;
					n_q <= count - CNT_W'(1);
					num_q <= DIV_W'(1) << FRAC_BITS;
					rem_q <= '0;
					quo_q <= '0;
					step_q <= STEP_W'(DIV_W - 1);
				end
			end
			B_DIV: begin
				if (sh >= {1'b0, n_q}) begin
					rem_q <= CNT_W'(sh - {1'b0, n_q});
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= CNT_W'(sh);
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
				num_q <= num_q << 1;
				step_q <= step_q - STEP_W'(1);
				idx_q <= '0;
				t_q <= '0;
				frac_q <= '0;
			end
			B_EMIT: begin
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
					if (frac_sum >= {1'b0, n_q}) begin
						frac_q <= CNT_W'(frac_sum - {1'b0, n_q});
						t_q <= t_q + quo_q + DIV_W'(1);
					end else begin
						frac_q <= CNT_W'(frac_sum);
						t_q <= t_q + quo_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		a_ax[0] = coef_q.a_x;
		a_ax[1] = coef_q.a_y;
		b_ax[0] = coef_q.b_x;
		b_ax[1] = coef_q.b_y;
		c_ax[0] = coef_q.c_x;
		c_ax[1] = coef_q.c_y;
		p0_ax[0] = coef_q.p0_x;
		p0_ax[1] = coef_q.p0_y;
		t_e = signed'({1'b0, t_q});
		for (int ax = 0; ax < 2; ax++) begin
			s1_d[ax] = S1_W'(a_ax[ax]) * S1_W'(t_e) + (S1_W'(b_ax[ax]) <<< FRAC_BITS);
			m2[ax] = M2_W'(s1_s1[ax]) * M2_W'(t_s1);
			s2_d[ax] = S2_W'(m2[ax] >>> FRAC_BITS) + (S2_W'(c_ax[ax]) <<< FRAC_BITS);
			m3[ax] = M3_W'(s2_s2[ax]) * M3_W'(t_s2);
			s3_d[ax] = S3_W'(m3[ax] >>> FRAC_BITS) + (S3_W'(p0_ax[ax]) <<< FRAC_BITS);
			rnd[ax] = (s3_s3[ax] + HALF) >>> FRAC_BITS;
			if (rnd[ax] > CMAX) sat[ax] = COORD_BITS'(CMAX);
			else if (rnd[ax] < CMIN) sat[ax] = COORD_BITS'(CMIN);
			else sat[ax] = COORD_BITS'(rnd[ax]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_e;
			idx_s1 <= idx_q;
			last_s1 <= (idx_q == n_q);
			t_s2 <= t_s1;
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
			for (int ax = 0; ax < 2; ax++) begin
				s1_s1[ax] <= s1_d[ax];
				s2_s2[ax] <= s2_d[ax];
				s3_s3[ax] <= s3_d[ax];
			end
			point_q.point_x <= sat[0];
			point_q.point_y <= sat[1];
			point_q.point_index <= IDX_W'(idx_s3);
			point_q.last_point <= last_s3;
		end
	end

endmodule

@@ hw/rtl/cubic_bezier_polyline_core.sv @@
// Flow: an accepted item passes F_SQ, F_SUM, F_ROOT and F_PUSH, then its coefficients
// and point count are queued; step division and pipeline fill precede the first point.
// Throughput: one point per cycle while points are taken; the setup of the next curve
// in the front end overlaps the evaluation of the current one.
// Reset: arst_n clears all control state at once; no clearing pass is needed.
module cubic_bezier_polyline_core #(
	parameter int MAX_POINTS = bzp_pkg::DEF_MAX_POINTS
) (
	input  logic clk,
	input  logic arst_n,
	input  bzp_pkg::curve_t curve,
	input  logic push,
	output logic full,
	output bzp_pkg::point_t point,
	output logic empty,
	input  logic pop
);
	import bzp_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int Q_W = $bits(coef_t) + CNT_W;

	coef_t f_coef, b_coef;
	logic [CNT_W-1:0] f_count, b_count;
	logic q_push, q_full, q_pop, q_empty;
	logic [Q_W-1:0] q_din, q_dout;

	bzp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.curve(curve),
		.push(push),
		.full(full),
		.coef(f_coef),
		.count(f_count),
		.q_push(q_push),
		.q_full(q_full)
	);

	assign q_din = {f_coef, f_count};

	bzp_queue #(.DATA_W(Q_W)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_push),
		.full(q_full),
		.din(q_din),
		.rd(q_pop),
		.empty(q_empty),
		.dout(q_dout)
	);

	assign b_coef = q_dout[Q_W-1:CNT_W];
	assign b_count = q_dout[CNT_W-1:0];

	bzp_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.coef(b_coef),
		.count(b_count),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.point(point),
		.empty(empty),
		.pop(pop)
	);

endmodule
